>>> hw/rtl/dcar_pkg.sv
// Shared types, constants and register map of the drift compensating audio resampler.
package dcar_pkg;

  localparam int FIFO_FRAMES_DEF = 32768;
  localparam int SAMPLE_W        = 16;
  localparam int PHASE_W         = 26;
  localparam int FILL_W          = 32;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;

  localparam logic [PHASE_W-1:0] ONE_Q24 = 26'h100_0000;
  localparam int ALPHA_Q24       = 167772;
  localparam int CORR_LIMIT_Q24  = 83886;

  localparam logic [15:0] MAX_QUEUED_RESET = 16'd24000;
  localparam logic [15:0] PRIME_RESET      = 16'd3840;
  localparam logic [15:0] TARGET_RESET     = 16'd2880;
  localparam logic [23:0] GAIN_RESET       = 24'd3817749;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_PULL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_MAX_QUEUED = 3'd1;
  localparam logic [2:0] REG_PRIME      = 3'd2;
  localparam logic [2:0] REG_TARGET     = 3'd3;
  localparam logic [2:0] REG_DRIFT_GAIN = 3'd4;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                       block_start;
    logic                       block_end;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       audio_valid;
    logic                       underrun_flag;
    logic                       primed_flag;
  } result_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] max_queued_frames;
    logic [15:0] prime_frames;
    logic [15:0] target_frames;
    logic [23:0] drift_gain;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               audio_valid;
    logic               underrun_flag;
    logic               primed_flag;
  } pull_meta_t;

endpackage

>>> hw/rtl/dcar_store.sv
// Frame store: one write port, two registered read ports.
module dcar_store #(
  parameter int FIFO_FRAMES = dcar_pkg::FIFO_FRAMES_DEF,
  localparam int AW = $clog2(FIFO_FRAMES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [31:0]   rd_data0,
  output logic [31:0]   rd_data1
);

  logic [31:0] mem [FIFO_FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

>>> hw/rtl/dcar_lane.sv
// One channel lane: linear interpolation between two frames, rounded and saturated.
module dcar_lane (
  input  logic                                 clk,
  input  logic                                 en1,
  input  logic                                 en2,
  input  logic signed [dcar_pkg::SAMPLE_W-1:0] a,
  input  logic signed [dcar_pkg::SAMPLE_W-1:0] b,
  input  logic [dcar_pkg::PHASE_W-1:0]         phase,
  output logic signed [dcar_pkg::SAMPLE_W-1:0] sample
);

  logic signed [16:0] delta;
  logic signed [43:0] prod;
  logic signed [15:0] a_q;
  logic signed [43:0] prod_q;
  logic signed [44:0] num;
  logic [44:0]        biased;
  logic signed [20:0] rounded;
  logic signed [15:0] sat;

  assign delta = 17'(b) - 17'(a);
  assign prod  = delta * $signed({1'b0, phase});

  always_ff @(posedge clk) begin
    if (en1) begin
      a_q    <= a;
      prod_q <= prod;
    end
  end

  always_comb begin
    num     = (45'(a_q) <<< 24) + 45'(prod_q);
    biased  = 45'(num) + 45'(24'h80_0000) - 45'(num[44]);
    rounded = $signed(biased[44:24]);
    if (rounded > 21'sd32767) begin
      sat = 16'sh7FFF;
    end else if (rounded < -21'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rounded[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sample <= sat;
    end
  end

endmodule

>>> hw/rtl/dcar_ctrl.sv
// FIFO pointers, playout phase and the fill filter / drift ratio sequencer.
module dcar_ctrl #(
  parameter int FIFO_FRAMES = dcar_pkg::FIFO_FRAMES_DEF,
  localparam int AW = $clog2(FIFO_FRAMES),
  localparam int CW = $clog2(FIFO_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  dcar_pkg::item_t      item,
  input  dcar_pkg::cfg_t       cfg,
  output logic                 busy,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [31:0]          wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr0,
  output logic [AW-1:0]        rd_addr1,
  output dcar_pkg::pull_meta_t meta
);

  localparam int PW = dcar_pkg::PHASE_W;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] NFR = SW'(FIFO_FRAMES);

  typedef enum logic [6:0] {
    UPD_IDLE     = 7'b0000001,
    UPD_FILL_MUL = 7'b0000010,
    UPD_FILL_ADD = 7'b0000100,
    UPD_ERR      = 7'b0001000,
    UPD_GAIN_MUL = 7'b0010000,
    UPD_RATIO    = 7'b0100000,
    UPD_ADVANCE  = 7'b1000000
  } upd_state_t;

  typedef struct packed {
    logic [PW-1:0] phase;
    logic [AW-1:0] rp;
    logic [CW-1:0] fc;
  } adv_t;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= NFR) begin
      sum = sum - NFR;
    end
    return sum[AW-1:0];
  endfunction

  function automatic adv_t advance(logic [PW-1:0] ph0, logic [PW-1:0] step,
                                   logic [AW-1:0] rp0, logic [CW-1:0] fc0);
    logic [PW-1:0] ph;
    logic [1:0]    whole;
    logic [1:0]    pops;
    adv_t          r;
    ph    = ph0 + step;
    whole = ph[PW-1:PW-2];
    pops  = (fc0 < CW'(whole)) ? fc0[1:0] : whole;
    r.phase = {whole - pops, ph[PW-3:0]};
    r.rp    = wrap_add(rp0, CW'(pops));
    r.fc    = fc0 - CW'(pops);
    return r;
  endfunction

  logic [AW-1:0]                rp, rp_next;
  logic [CW-1:0]                fc, fc_next;
  logic [PW-1:0]                phase, phase_next;
  logic [PW-1:0]                ratio, ratio_next;
  logic [dcar_pkg::FILL_W-1:0]  ff, ff_next;
  logic                         primed, primed_next;
  logic                         under_seen, under_seen_next;
  upd_state_t                   upd, upd_next;
  logic signed [33:0]           opnd, opnd_next;
  logic signed [58:0]           prod, prod_next;
  logic                         adv_pend, adv_pend_next;
  logic                         reprime_pend, reprime_pend_next;

  logic signed [24:0]           mul_b;
  logic signed [58:0]           mul;
  logic [58:0]                  biased24;
  logic [58:0]                  biased32;
  logic signed [26:0]           corr_full;
  logic signed [26:0]           corr;
  logic [CW-1:0]                limit;
  logic [dcar_pkg::FILL_W-1:0]  target_fill;
  logic [dcar_pkg::FILL_W-1:0]  ff_base;
  logic                         priming;
  logic                         primed_mid;
  logic                         good;
  logic                         under;
  logic                         under_new;
  logic                         reprime;
  adv_t                         adv;

  assign busy     = (upd != UPD_IDLE);
  assign wr_addr  = wrap_add(rp, fc);
  assign wr_data  = {item.in_right, item.in_left};
  assign rd_addr0 = rp;
  assign rd_addr1 = wrap_add(rp, CW'(1));

  assign target_fill = {cfg.target_frames, 16'd0};
  assign mul_b = (upd == UPD_GAIN_MUL) ? $signed({1'b0, cfg.drift_gain})
                                       : $signed(25'(dcar_pkg::ALPHA_Q24));
  assign mul   = opnd * mul_b;
  assign adv   = advance(phase, ratio, rp, fc);

  always_comb begin
    biased24  = 59'(prod) + 59'(24'h80_0000) - 59'(prod[58]);
    biased32  = 59'(prod) + 59'(32'h8000_0000) - 59'(prod[58]);
    corr_full = $signed(biased32[58:32]);
    if (corr_full > 27'sd83886) begin
      corr = 27'sd83886;
    end else if (corr_full < -27'sd83886) begin
      corr = -27'sd83886;
    end else begin
      corr = corr_full;
    end
  end

  always_comb begin
    if (cfg.max_queued_frames == 16'd0) begin
      limit = CW'(1);
    end else if (32'(cfg.max_queued_frames) > FIFO_FRAMES) begin
      limit = CW'(FIFO_FRAMES);
    end else begin
      limit = CW'(cfg.max_queued_frames);
    end
  end

  always_comb begin
    priming    = item.block_start && !primed && (32'(fc) >= 32'(cfg.prime_frames));
    primed_mid = primed || priming;
    good       = primed_mid && (fc >= CW'(2));
    under      = primed_mid && !good;
    under_new  = (item.block_start ? 1'b0 : under_seen) || under;
    reprime    = item.block_end && under_new;
    ff_base    = priming ? target_fill : ff;
    meta.phase         = priming ? '0 : phase;
    meta.audio_valid   = good;
    meta.underrun_flag = under;
    meta.primed_flag   = primed_mid && !reprime;
  end

  always_comb begin
    rp_next           = rp;
    fc_next           = fc;
    phase_next        = phase;
    ratio_next        = ratio;
    ff_next           = ff;
    primed_next       = primed;
    under_seen_next   = under_seen;
    upd_next          = upd;
    opnd_next         = opnd;
    prod_next         = prod;
    adv_pend_next     = adv_pend;
    reprime_pend_next = reprime_pend;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    unique case (upd)
      UPD_IDLE: begin
        if (accept) begin
          unique case (item.func)
            dcar_pkg::FUNC_PUSH: begin
              if (cfg.enable) begin
                wr_en = 1'b1;
                if (fc >= limit) begin
                  rp_next = wrap_add(rp, fc - limit + CW'(1));
                  fc_next = limit;
                end else begin
                  fc_next = fc + CW'(1);
                end
              end
            end
            dcar_pkg::FUNC_PULL: begin
              rd_en           = 1'b1;
              primed_next     = meta.primed_flag;
              under_seen_next = item.block_end ? 1'b0 : under_new;
              if (item.block_start && primed_mid) begin
                ff_next           = ff_base;
                phase_next        = meta.phase;
                opnd_next         = $signed((34'(fc) << 16) - 34'(ff_base));
                adv_pend_next     = good;
                reprime_pend_next = reprime;
                upd_next          = UPD_FILL_MUL;
              end else begin
                if (item.block_start) begin
                  ratio_next = dcar_pkg::ONE_Q24;
                end
                if (good) begin
                  phase_next = adv.phase;
                  rp_next    = adv.rp;
                  fc_next    = adv.fc;
                end
                if (reprime) begin
                  phase_next = '0;
                  ff_next    = target_fill;
                end
              end
            end
            dcar_pkg::FUNC_CLEAR: begin
              rp_next         = '0;
              fc_next         = '0;
              phase_next      = '0;
              ratio_next      = dcar_pkg::ONE_Q24;
              ff_next         = target_fill;
              primed_next     = 1'b0;
              under_seen_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      UPD_FILL_MUL: begin
        prod_next = mul;
        upd_next  = UPD_FILL_ADD;
      end
      UPD_FILL_ADD: begin
        ff_next  = ff + biased24[55:24];
        upd_next = UPD_ERR;
      end
      UPD_ERR: begin
        opnd_next = $signed(34'(ff) - 34'(target_fill));
        upd_next  = UPD_GAIN_MUL;
      end
      UPD_GAIN_MUL: begin
        prod_next = mul;
        upd_next  = UPD_RATIO;
      end
      UPD_RATIO: begin
        ratio_next = dcar_pkg::ONE_Q24 + PW'(corr);
        upd_next   = UPD_ADVANCE;
      end
      UPD_ADVANCE: begin
        if (adv_pend) begin
          phase_next = adv.phase;
          rp_next    = adv.rp;
          fc_next    = adv.fc;
        end
        if (reprime_pend) begin
          phase_next = '0;
          ff_next    = target_fill;
        end
        upd_next = UPD_IDLE;
      end
      default: begin
        upd_next = UPD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp         <= '0;
      fc         <= '0;
      phase      <= '0;
      ratio      <= dcar_pkg::ONE_Q24;
      ff         <= {dcar_pkg::TARGET_RESET, 16'd0};
      primed     <= 1'b0;
      under_seen <= 1'b0;
      upd        <= UPD_IDLE;
    end else begin
      rp         <= rp_next;
      fc         <= fc_next;
      phase      <= phase_next;
      ratio      <= ratio_next;
      ff         <= ff_next;
      primed     <= primed_next;
      under_seen <= under_seen_next;
      upd        <= upd_next;
    end
  end

  always_ff @(posedge clk) begin
    opnd         <= opnd_next;
    prod         <= prod_next;
    adv_pend     <= adv_pend_next;
    reprime_pend <= reprime_pend_next;
  end

endmodule

>>> hw/rtl/drift_compensating_audio_resampler.sv
// Drift compensating stereo resampler: an elastic FIFO of 16-bit stereo frames played out
// through a linear interpolator whose step is trimmed once per sink block to hold the fill
// near target_frames. Push, clear and pull words are taken one per cycle while the block
// is idle and the result pipeline has room; a pull that opens a block while playout is
// primed holds the input while the shared multiplier runs the fill filter and the ratio
// update. A pull's result comes from a two-stage left/right lane pipeline fed by the two
// read ports of the frame store; up to three results wait for the sink before input stalls.
module drift_compensating_audio_resampler #(
  parameter int FIFO_FRAMES = dcar_pkg::FIFO_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  dcar_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output dcar_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcar_pkg::PADDR_W-1:0]  paddr,
  input  logic [dcar_pkg::PDATA_W-1:0]  pwdata,
  output logic [dcar_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = $clog2(FIFO_FRAMES);

  dcar_pkg::cfg_t       cfg;
  dcar_pkg::pull_meta_t meta;
  dcar_pkg::pull_meta_t meta0, meta1, meta2;

  logic          accept;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr0, rd_addr1;
  logic [31:0]   rd_data0, rd_data1;
  logic          v0, v1, v2;
  logic          adv0, adv1, adv2;
  logic signed [dcar_pkg::SAMPLE_W-1:0] lane_left, lane_right;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable            <= 1'b0;
      cfg.max_queued_frames <= dcar_pkg::MAX_QUEUED_RESET;
      cfg.prime_frames      <= dcar_pkg::PRIME_RESET;
      cfg.target_frames     <= dcar_pkg::TARGET_RESET;
      cfg.drift_gain        <= dcar_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        dcar_pkg::REG_ENABLE:     cfg.enable            <= pwdata[0];
        dcar_pkg::REG_MAX_QUEUED: cfg.max_queued_frames <= pwdata[15:0];
        dcar_pkg::REG_PRIME:      cfg.prime_frames      <= pwdata[15:0];
        dcar_pkg::REG_TARGET:     cfg.target_frames     <= pwdata[15:0];
        dcar_pkg::REG_DRIFT_GAIN: cfg.drift_gain        <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dcar_pkg::REG_ENABLE:     prdata = 32'(cfg.enable);
      dcar_pkg::REG_MAX_QUEUED: prdata = 32'(cfg.max_queued_frames);
      dcar_pkg::REG_PRIME:      prdata = 32'(cfg.prime_frames);
      dcar_pkg::REG_TARGET:     prdata = 32'(cfg.target_frames);
      dcar_pkg::REG_DRIFT_GAIN: prdata = 32'(cfg.drift_gain);
      default:                  prdata = '0;
    endcase
  end

  assign adv2       = !v2 || result_ready;
  assign adv1       = !v1 || adv2;
  assign adv0       = !v0 || adv1;
  assign item_ready = !busy && adv0;
  assign accept     = item_valid && item_ready;

  dcar_ctrl #(.FIFO_FRAMES(FIFO_FRAMES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .meta     (meta)
  );

  dcar_store #(.FIFO_FRAMES(FIFO_FRAMES)) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  dcar_lane u_lane_left (
    .clk    (clk),
    .en1    (adv1),
    .en2    (adv2),
    .a      ($signed(rd_data0[15:0])),
    .b      ($signed(rd_data1[15:0])),
    .phase  (meta0.phase),
    .sample (lane_left)
  );

  dcar_lane u_lane_right (
    .clk    (clk),
    .en1    (adv1),
    .en2    (adv2),
    .a      ($signed(rd_data0[31:16])),
    .b      ($signed(rd_data1[31:16])),
    .phase  (meta0.phase),
    .sample (lane_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rd_en) begin
        v0 <= 1'b1;
      end else if (adv1) begin
        v0 <= 1'b0;
      end
      if (adv1) begin
        v1 <= v0;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      meta0 <= meta;
    end
    if (adv1) begin
      meta1 <= meta0;
    end
    if (adv2) begin
      meta2 <= meta1;
    end
  end

  assign result_valid         = v2;
  assign result.out_left      = meta2.audio_valid ? lane_left : '0;
  assign result.out_right     = meta2.audio_valid ? lane_right : '0;
  assign result.audio_valid   = meta2.audio_valid;
  assign result.underrun_flag = meta2.underrun_flag;
  assign result.primed_flag   = meta2.primed_flag;

endmodule

>>> hw/rtl/dcar_checker.sv
// Port-level checks of the resampler, bound to the top level.
module dcar_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input dcar_pkg::item_t               item,
  input logic                          result_valid,
  input logic                          result_ready,
  input dcar_pkg::result_t             result,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [dcar_pkg::PADDR_W-1:0]  paddr,
  input logic [dcar_pkg::PDATA_W-1:0]  pwdata,
  input logic [dcar_pkg::PDATA_W-1:0]  prdata,
  input logic                          pready
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_silence_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.audio_valid |->
      result.out_left == 16'sd0 && result.out_right == 16'sd0)
    else $error("silent result word carries samples");

  a_underrun_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.underrun_flag |-> !result.audio_valid && result.primed_flag == 1'b0
      || result_valid && result.underrun_flag && !result.audio_valid)
    else $error("underrun flagged on an interpolated word");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("configuration access stalled");

endmodule

bind drift_compensating_audio_resampler dcar_checker u_checker (.*);

>>> dv/resampler_checker.sv
// Checker for the resampler: watches both word channels and the register port, predicts, compares.
module resampler_checker #(
  parameter int FIFO_FRAMES = dcar_pkg::FIFO_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_ready,
  input  dcar_pkg::item_t              item,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  dcar_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [dcar_pkg::PADDR_W-1:0] paddr,
  input  logic [dcar_pkg::PDATA_W-1:0] pwdata,
  output int                           errors,
  output int                           pending,
  output int                           pulls,
  output int                           audio_frames,
  output int                           underruns
);

  localparam int PW        = dcar_pkg::PHASE_W;
  localparam int FW        = dcar_pkg::FILL_W;
  localparam int DUE_DEPTH = 64;

  dcar_pkg::cfg_t    cfg;
  logic [31:0]       frame_mem [FIFO_FRAMES];
  int unsigned       rd_ptr;
  int unsigned       fill;
  logic [PW-1:0]     phase_acc;
  logic [PW-1:0]     step;
  logic [FW-1:0]     fill_avg;
  logic              primed;
  logic              under_seen;
  dcar_pkg::result_t due_ring [DUE_DEPTH];
  int                due_head;
  int                due_tail;
  int                due_count;

  function automatic longint round_shift(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic [15:0] lerp(input logic signed [15:0] a, input logic signed [15:0] b);
    longint s;
    s = round_shift(longint'(a) * (longint'(1) << 24) +
                    (longint'(b) - longint'(a)) * longint'(phase_acc), 24);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  task automatic drop_frames(int unsigned n);
    rd_ptr = (rd_ptr + n) % FIFO_FRAMES;
    fill   = fill - n;
  endtask

  task automatic clear_state();
    rd_ptr     = 0;
    fill       = 0;
    phase_acc  = '0;
    step       = dcar_pkg::ONE_Q24;
    fill_avg   = {cfg.target_frames, 16'h0000};
    primed     = 1'b0;
    under_seen = 1'b0;
  endtask

  task automatic file_due(input dcar_pkg::result_t r);
    due_ring[due_tail] = r;
    due_tail           = (due_tail + 1) % DUE_DEPTH;
    due_count++;
  endtask

  task automatic trim_ratio();
    longint diff;
    longint err;
    longint corr;
    if (!primed && fill >= 32'(cfg.prime_frames)) begin
      primed    = 1'b1;
      fill_avg  = {cfg.target_frames, 16'h0000};
      phase_acc = '0;
    end
    if (primed) begin
      diff     = (longint'(fill) << 16) - longint'(fill_avg);
      fill_avg = FW'(longint'(fill_avg) + round_shift(diff * dcar_pkg::ALPHA_Q24, 24));
      err      = longint'(fill_avg) - (longint'(cfg.target_frames) << 16);
      corr     = round_shift(err * longint'(cfg.drift_gain), 32);
      if (corr > dcar_pkg::CORR_LIMIT_Q24) corr = dcar_pkg::CORR_LIMIT_Q24;
      if (corr < -dcar_pkg::CORR_LIMIT_Q24) corr = -dcar_pkg::CORR_LIMIT_Q24;
      step = PW'(longint'(dcar_pkg::ONE_Q24) + corr);
    end else begin
      step = dcar_pkg::ONE_Q24;
    end
  endtask

  task automatic predict_frame(input dcar_pkg::item_t w);
    dcar_pkg::result_t r;
    logic [31:0]       fa;
    logic [31:0]       fb;
    int unsigned       lim;
    case (w.func)
      dcar_pkg::FUNC_PUSH: begin
        if (cfg.enable) begin
          lim = 32'(cfg.max_queued_frames);
          if (lim < 1) lim = 1;
          if (lim > FIFO_FRAMES) lim = FIFO_FRAMES;
          if (fill >= lim) drop_frames(fill - lim + 1);
          frame_mem[(rd_ptr + fill) % FIFO_FRAMES] = {w.in_right, w.in_left};
          fill++;
        end
      end
      dcar_pkg::FUNC_CLEAR: clear_state();
      dcar_pkg::FUNC_PULL: begin
        r = '0;
        if (w.block_start) begin
          under_seen = 1'b0;
          trim_ratio();
        end
        if (primed && fill >= 2) begin
          fa = frame_mem[rd_ptr];
          fb = frame_mem[(rd_ptr + 1) % FIFO_FRAMES];
          r.out_left    = lerp(fa[15:0], fb[15:0]);
          r.out_right   = lerp(fa[31:16], fb[31:16]);
          r.audio_valid = 1'b1;
          phase_acc = phase_acc + step;
          while (phase_acc >= dcar_pkg::ONE_Q24 && fill >= 1) begin
            drop_frames(1);
            phase_acc = phase_acc - dcar_pkg::ONE_Q24;
          end
        end else if (primed) begin
          r.underrun_flag = 1'b1;
          under_seen      = 1'b1;
        end
        if (w.block_end) begin
          if (under_seen) begin
            primed    = 1'b0;
            phase_acc = '0;
            fill_avg  = {cfg.target_frames, 16'h0000};
          end
          under_seen = 1'b0;
        end
        r.primed_flag = primed;
        file_due(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    dcar_pkg::result_t due;
    if (rst) begin
      cfg = '{1'b0, dcar_pkg::MAX_QUEUED_RESET, dcar_pkg::PRIME_RESET,
              dcar_pkg::TARGET_RESET, dcar_pkg::GAIN_RESET};
      clear_state();
      due_head  = 0;
      due_tail  = 0;
      due_count = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[dcar_pkg::PADDR_W-1:2])
          dcar_pkg::REG_ENABLE:     cfg.enable            = pwdata[0];
          dcar_pkg::REG_MAX_QUEUED: cfg.max_queued_frames = pwdata[15:0];
          dcar_pkg::REG_PRIME:      cfg.prime_frames      = pwdata[15:0];
          dcar_pkg::REG_TARGET:     cfg.target_frames     = pwdata[15:0];
          dcar_pkg::REG_DRIFT_GAIN: cfg.drift_gain        = pwdata[23:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (due_count == 0) begin
          report_mismatch("output word with no frame due");
        end else begin
          due      = due_ring[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_count--;
          if ($isunknown(result)) report_mismatch("output word carries unknown bits");
          check_field("out_left", result.out_left, due.out_left);
          check_field("out_right", result.out_right, due.out_right);
          check_field("audio_valid", result.audio_valid, due.audio_valid);
          check_field("underrun_flag", result.underrun_flag, due.underrun_flag);
          check_field("primed_flag", result.primed_flag, due.primed_flag);
          pulls++;
          if (due.audio_valid) audio_frames++;
          if (due.underrun_flag) underruns++;
        end
      end
      if (item_valid && item_ready) predict_frame(item);
      pending <= due_count;
    end
  end

endmodule

>>> dv/tb_top.sv
// Top of the resampler regression: clock, reset, word and register stimulus, verdict.
module tb_top;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 200;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         item_valid   = 1'b0;
  logic                         item_ready;
  dcar_pkg::item_t              item         = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b1;
  dcar_pkg::result_t            result;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [dcar_pkg::PADDR_W-1:0] paddr        = '0;
  logic [dcar_pkg::PDATA_W-1:0] pwdata       = '0;
  logic [dcar_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int errors;
  int pending;
  int pulls;
  int audio_frames;
  int underruns;
  int send_idle  = 0;
  int sink_stall = 0;
  int hold_req   = 0;
  int words_sent = 0;

  // enable, max_queued_frames, prime_frames, target_frames, drift_gain
  int unsigned settings [PHASES][5] = '{
    '{1, 16,    4,     8,     16777215},
    '{1, 1,     0,     0,     0},
    '{1, 0,     1,     65535, 16777215},
    '{1, 65535, 40,    60,    3817749},
    '{0, 8,     2,     4,     1000},
    '{1, 32768, 65535, 0,     16777215},
    '{1, 6,     3,     3,     8388608},
    '{1, 24,    0,     12,    123456}
  };
  int push_bias      [PHASES] = '{0, 0, 0, 2, 0, 0, 0, 0};
  int send_idle_mix  [4]      = '{0, 73, 0, 9};
  int sink_stall_mix [4]      = '{0, 0, 73, 9};

  drift_compensating_audio_resampler i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  resampler_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending),
    .pulls        (pulls),
    .audio_frames (audio_frames),
    .underruns    (underruns)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("drift_compensating_audio_resampler regression: fail");
    $finish;
  end

  function automatic dcar_pkg::item_t word(input logic [1:0] f, input logic [15:0] l,
                                           input logic [15:0] rt, input logic bs,
                                           input logic be);
    dcar_pkg::item_t w;
    w.func        = f;
    w.in_left     = l;
    w.in_right    = rt;
    w.block_start = bs;
    w.block_end   = be;
    return w;
  endfunction

  function automatic logic [15:0] sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input dcar_pkg::item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    words_sent++;
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned en, input int unsigned mq, input int unsigned pf,
                           input int unsigned tf, input int unsigned gain);
    apb_write(dcar_pkg::REG_ENABLE, en);
    apb_write(dcar_pkg::REG_MAX_QUEUED, mq);
    apb_write(dcar_pkg::REG_PRIME, pf);
    apb_write(dcar_pkg::REG_TARGET, tf);
    apb_write(dcar_pkg::REG_DRIFT_GAIN, gain);
  endtask

  initial begin : sink
    int hold;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold     = hold_req;
        hold_req = 0;
        result_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  initial begin : stimulus
    int  r;
    int  len;
    int  np;
    int  done;
    bit  held;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(word(dcar_pkg::FUNC_PUSH, 16'h7fff, 16'h8000, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b1));
    send_word(word(FUNC_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1));
    send_word(word(dcar_pkg::FUNC_CLEAR, 16'h0000, 16'h0000, 1'b0, 1'b0));
    drain();
    configure(1, 4, 2, 3, 24'hffffff);
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h8000, 16'h8000, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h7fff, 16'h7fff, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h8000, 16'h7fff, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h7fff, 16'h8000, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h0000, 16'hffff, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b0, 1'b1));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b1));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h0001, 16'h8001, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PUSH, 16'hffff, 16'h7ffe, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b1));
    send_word(word(dcar_pkg::FUNC_CLEAR, 16'h0000, 16'h0000, 1'b1, 1'b1));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b0));
    repeat (4) send_word(word(dcar_pkg::FUNC_PUSH, sample(), sample(), 1'b0, 1'b0));
    drain();
    // lower the limit below the current fill
    apb_write(dcar_pkg::REG_MAX_QUEUED, 2);
    send_word(word(dcar_pkg::FUNC_PUSH, 16'h1234, 16'hedcb, 1'b0, 1'b0));
    send_word(word(dcar_pkg::FUNC_PULL, 16'h0000, 16'h0000, 1'b1, 1'b1));

    held = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(settings[p][0], settings[p][1], settings[p][2], settings[p][3], settings[p][4]);
      send_idle  = send_idle_mix[p % 4];
      sink_stall = sink_stall_mix[p % 4];
      done = 0;
      while (done < PHASE_WORDS) begin
        if (p == 3 && done >= 60 && !held) begin
          hold_req = 400;
          held     = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 4) begin
          send_word(word(dcar_pkg::FUNC_CLEAR, sample(), sample(), 1'($urandom),
                         1'($urandom)));
          done++;
        end else if (r < 7) begin
          send_word(word(FUNC_UNUSED, sample(), sample(), 1'($urandom), 1'($urandom)));
          done++;
        end else if (r < 14) begin
          send_word(word(dcar_pkg::FUNC_PULL, sample(), sample(), 1'($urandom),
                         1'($urandom)));
          done++;
        end else begin
          len = $urandom_range(1, 6);
          np  = $urandom_range(0, 2 * len + push_bias[p]);
          repeat (np) send_word(word(dcar_pkg::FUNC_PUSH, sample(), sample(), 1'($urandom),
                                     1'($urandom)));
          done += np;
          for (int k = 0; k < len; k++)
            send_word(word(dcar_pkg::FUNC_PULL, sample(), sample(), k == 0, k == len - 1));
          done += len;
        end
      end
    end
    drain();

    $display("run covered %0d words, %0d output frames (%0d interpolated, %0d underrun)",
             words_sent, pulls, audio_frames, underruns);
    $display("across %0d register settings, four flow-control mixes and a long sink hold-off",
             PHASES + 1);
    if (errors == 0 && pending == 0) begin
      $display("drift_compensating_audio_resampler regression: pass");
    end else begin
      $display("drift_compensating_audio_resampler regression: fail");
    end
    $finish;
  end

endmodule
